### hw/rtl/gvwt_pkg.sv
package gvwt_pkg;

    localparam int MaxGridVertices   = 65536;
    localparam int SlotsPerVertex    = 8;
    localparam int MaxStoredVertices = 262144;

    localparam int GridAw  = $clog2(MaxGridVertices);
    localparam int SlotAw  = $clog2(MaxGridVertices * SlotsPerVertex);
    localparam int SlotSw  = $clog2(SlotsPerVertex);
    localparam int StoreAw = $clog2(MaxStoredVertices);
    localparam int CountW  = StoreAw + 1;

    localparam logic [1:0] RegCellsI = 2'd0;
    localparam logic [1:0] RegCellsJ = 2'd1;
    localparam logic [1:0] RegCellsK = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INDEX,
        ST_OWN_RD,
        ST_OWN_CHK,
        ST_OWN_CMP,
        ST_NB_RD,
        ST_NB_CHK,
        ST_NB_CMP,
        ST_FINISH,
        ST_OUT,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic [StoreAw-1:0] vertex_index;
        logic               is_new;
        logic               slots_full;
        logic               store_full;
        logic [CountW-1:0]  vertex_total;
    } t_result;

    function automatic logic dbl_eq(input logic [63:0] a, input logic [63:0] b);
        logic nan_a;
        logic nan_b;
        nan_a = (a[62:0] > 63'h7FF0000000000000);
        nan_b = (b[62:0] > 63'h7FF0000000000000);
        if (nan_a || nan_b) return 1'b0;
        if (a[62:0] == '0 && b[62:0] == '0) return 1'b1;
        return a == b;
    endfunction

endpackage

### hw/rtl/gvwt_store.sv
module gvwt_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [gvwt_pkg::StoreAw-1:0] i_waddr,
    input  logic [191:0]                i_wdata,
    input  logic [gvwt_pkg::StoreAw-1:0] i_raddr,
    output logic [191:0]                o_rdata
);
    import gvwt_pkg::*;

    logic [191:0] r_mem [MaxStoredVertices];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hw/rtl/grid_vertex_weld_table.sv
// From item accept to result the slot table is read one slot at a time, each occupied slot
// also compared with its stored point; a search ending at an empty own slot ends in ST_FINISH.
// One item is in work at a time, set by the single read port of the slot table
// and of the vertex store; the next item is taken only after the result is accepted.
// Reset (i_rst_n low, synchronous) returns the registers to 1, the vertex
// count to 0, and starts a clearing pass over the slot table.
module grid_vertex_weld_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data,
    // input item: vert_i[7:0], vert_j[15:8], vert_k[23:16], coord_x[87:24],
    // coord_y[151:88], coord_z[215:152]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [215:0] s_axis_tdata,
    // result item: vertex_index[17:0], is_new[18], slots_full[19],
    // store_full[20], vertex_total[39:21]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata
);
    import gvwt_pkg::*;

    // slot table: valid bit plus vertex number
    logic [StoreAw:0] r_slot [MaxGridVertices * SlotsPerVertex];

    t_state r_state, n_state;
    logic [7:0]  r_ni, r_nj, r_nk;
    logic [7:0]  r_vi, r_vj, r_vk;
    logic [63:0] r_x, r_y, r_z;
    logic [GridAw-1:0] r_g, r_gm, r_gp;
    logic [15:0] r_nij;
    logic [SlotSw-1:0] r_s, r_ns;
    logic        r_side; // 0: k-1 layer, 1: k+1 layer
    logic [StoreAw:0] r_e;
    logic [StoreAw-1:0] r_res;
    logic [CountW-1:0] r_count;
    logic [SlotAw-1:0] r_clr;
    logic        r_found;
    logic [StoreAw-1:0] r_fvert;
    t_result     r_out;
    logic        r_ovalid;

    // slot memory control
    logic              slot_we;
    logic [SlotAw-1:0] slot_waddr, slot_raddr;
    logic [StoreAw:0]  slot_wdata;
    logic              store_we;
    logic [191:0]      store_rdata;
    logic              pt_eq;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_out.vertex_total, r_out.store_full, r_out.slots_full,
                            r_out.is_new, r_out.vertex_index};

    assign pt_eq = dbl_eq(store_rdata[63:0], r_x) && dbl_eq(store_rdata[127:64], r_y)
                && dbl_eq(store_rdata[191:128], r_z);

    always_comb begin
        unique case (r_state)
            ST_OWN_RD: slot_raddr = {r_g, r_s};
            ST_NB_RD:  slot_raddr = {(r_side ? r_gp : r_gm), r_ns};
            default:   slot_raddr = {r_g, r_s};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot[slot_waddr] <= slot_wdata;
        end
        r_e <= r_slot[slot_raddr];
    end

    gvwt_store u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[StoreAw-1:0]),
        .i_wdata ({r_z, r_y, r_x}),
        .i_raddr (r_e[StoreAw-1:0]),
        .o_rdata (store_rdata)
    );

    // grid index products kept narrow: only the low GridAw bits matter
    logic [GridAw-1:0] lin_base, lin_kk;
    logic [8:0] ni1, nj1;
    assign ni1 = {1'b0, r_ni} + 9'd1;
    assign nj1 = {1'b0, r_nj} + 9'd1;
    assign lin_base = GridAw'(r_vj * ni1 + {8'd0, r_vi});
    assign lin_kk   = GridAw'(r_vk * r_nij);

    logic want_new, k_lo_ok, k_hi_ok;
    assign k_lo_ok = (r_vk != 8'd0);
    assign k_hi_ok = (r_vk < r_nk);

    always_comb begin
        n_state    = r_state;
        slot_we    = 1'b0;
        slot_waddr = {r_g, r_s};
        slot_wdata = '0;
        store_we   = 1'b0;
        want_new   = 1'b0;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid && s_axis_tready) n_state = ST_INDEX;
            ST_INDEX: n_state = ST_OWN_RD;
            ST_OWN_RD: n_state = ST_OWN_CHK;
            ST_OWN_CHK: begin
                if (!r_e[StoreAw]) begin
                    if (k_lo_ok || k_hi_ok) n_state = ST_NB_RD;
                    else n_state = ST_FINISH;
                end else begin
                    n_state = ST_OWN_CMP;
                end
            end
            ST_OWN_CMP: begin
                if (pt_eq || r_s == SlotSw'(SlotsPerVertex - 1)) n_state = ST_OUT;
                else n_state = ST_OWN_RD;
            end
            ST_NB_RD: n_state = ST_NB_CHK;
            ST_NB_CHK: begin
                if (!r_e[StoreAw]) begin
                    if (!r_side && k_hi_ok) n_state = ST_NB_RD;
                    else n_state = ST_FINISH;
                end else begin
                    n_state = ST_NB_CMP;
                end
            end
            ST_NB_CMP: begin
                if (pt_eq) n_state = ST_FINISH;
                else if (r_ns != SlotSw'(SlotsPerVertex - 1)) n_state = ST_NB_RD;
                else if (!r_side && k_hi_ok) n_state = ST_NB_RD;
                else n_state = ST_FINISH;
            end
            ST_FINISH: begin
                n_state = ST_OUT;
                if (r_found) begin
                    slot_we    = 1'b1;
                    slot_wdata = {1'b1, r_fvert};
                end else if (r_count < CountW'(MaxStoredVertices)) begin
                    want_new   = 1'b1;
                    slot_we    = 1'b1;
                    slot_wdata = {1'b1, r_count[StoreAw-1:0]};
                    store_we   = 1'b1;
                end
            end
            ST_OUT: n_state = ST_IDLE;
            ST_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                if (r_clr == SlotAw'(MaxGridVertices * SlotsPerVertex - 1)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_ni     <= 8'd1;
            r_nj     <= 8'd1;
            r_nk     <= 8'd1;
            r_count  <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    RegCellsI: r_ni <= i_cfg_data;
                    RegCellsJ: r_nj <= i_cfg_data;
                    RegCellsK: r_nk <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (want_new) r_count <= r_count + 1'b1;
            if (r_state == ST_OUT) r_ovalid <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_vi <= s_axis_tdata[7:0];
                r_vj <= s_axis_tdata[15:8];
                r_vk <= s_axis_tdata[23:16];
                r_x  <= s_axis_tdata[87:24];
                r_y  <= s_axis_tdata[151:88];
                r_z  <= s_axis_tdata[215:152];
                r_nij <= 16'(ni1 * nj1);
                r_s   <= '0;
                r_found <= 1'b0;
            end
            ST_INDEX: begin
                r_g   <= lin_kk + lin_base;
                r_gm  <= lin_kk + lin_base - r_nij[GridAw-1:0];
                r_gp  <= lin_kk + lin_base + r_nij[GridAw-1:0];
                r_ns   <= '0;
                r_side <= !k_lo_ok;
            end
            ST_OWN_CHK: r_res <= r_e[StoreAw-1:0];
            ST_OWN_CMP: begin
                if (pt_eq) begin
                    r_out <= '{r_res, 1'b0, 1'b0, 1'b0, r_count};
                end else if (r_s == SlotSw'(SlotsPerVertex - 1)) begin
                    r_out <= '{r_res, 1'b0, 1'b1, 1'b0, r_count};
                end
                r_s <= r_s + 1'b1;
            end
            ST_NB_CHK: begin
                r_fvert <= r_e[StoreAw-1:0];
                if (!r_e[StoreAw]) begin
                    r_side <= 1'b1;
                    r_ns   <= '0;
                end
            end
            ST_NB_CMP: begin
                if (pt_eq) begin
                    r_found <= 1'b1;
                end else if (r_ns == SlotSw'(SlotsPerVertex - 1)) begin
                    r_side <= 1'b1;
                    r_ns   <= '0;
                end else begin
                    r_ns <= r_ns + 1'b1;
                end
            end
            ST_FINISH: begin
                if (r_found) r_out <= '{r_fvert, 1'b0, 1'b0, 1'b0, r_count};
                else if (want_new)
                    r_out <= '{r_count[StoreAw-1:0], 1'b1, 1'b0, 1'b0, r_count + 1'b1};
                else r_out <= '{'0, 1'b0, 1'b0, 1'b1, r_count};
            end
            default: ;
        endcase
    end

    // appended vertex count never exceeds the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(MaxStoredVertices)) else $error("vertex count overflow");
    // input is refused while a result waits
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready) else $error("accept while result pending");
    // an append advances the count by exactly one
    a_append_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        want_new |=> r_count == $past(r_count) + 1'b1) else $error("bad append");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import gvwt_pkg::*;

    // No item moves for this many cycles: declare a hang. It covers the
    // clearing pass of the slot table after reset with margin.
    localparam int unsigned HangLimit = 2200000;
    // Settle a bit past the worst result latency.
    localparam int          SettleCycles = 100;
    localparam int          PhaseItems = 89;

    localparam logic [63:0] F_ONE  = 64'h3FF0000000000000;
    localparam logic [63:0] F_TWO  = 64'h4000000000000000;
    localparam logic [63:0] F_MONE = 64'hBFF0000000000000;
    localparam logic [63:0] F_PZ   = 64'h0000000000000000;
    localparam logic [63:0] F_NZ   = 64'h8000000000000000;
    localparam logic [63:0] F_QNAN = 64'h7FF8000000000000;
    localparam logic [63:0] F_INF  = 64'h7FF0000000000000;
    localparam logic [63:0] F_MAX  = 64'h7FEFFFFFFFFFFFFF;
    localparam logic [63:0] F_ONES = 64'hFFFFFFFFFFFFFFFF;

    typedef struct packed {
        logic [17:0] vtx;
        logic        fresh;
        logic        slots_full;
        logic        store_full;
        logic [18:0] total;
    } weld_t;

    typedef struct packed {
        logic [7:0]  vi;
        logic [7:0]  vj;
        logic [7:0]  vk;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic        typed;
        weld_t       want;
    } corner_row_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [7:0]   i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [215:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [39:0]  m_axis_tdata;

    grid_vertex_weld_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Weld predictor: own copy of the slot table, vertex store and grid size
    // ------------------------------------------------------------------
    int unsigned slot_map [int unsigned];   // absent entry means empty slot
    logic [63:0] pos_x [int unsigned];
    logic [63:0] pos_y [int unsigned];
    logic [63:0] pos_z [int unsigned];
    int unsigned vertex_count;
    int unsigned cells_i, cells_j, cells_k;

    weld_t       expected_welds [$];
    int          errors;
    logic        long_hold_req;
    logic        rx_no_stall;

    // IEEE equality on bit patterns: NaN never matches, signed zeros match
    function automatic bit ieee_equal(logic [63:0] a, logic [63:0] b);
        if (a[62:0] > 63'h7FF0000000000000 || b[62:0] > 63'h7FF0000000000000)
            return 1'b0;
        if (a[62:0] == '0 && b[62:0] == '0)
            return 1'b1;
        return a == b;
    endfunction

    function automatic bit point_matches(int unsigned v, logic [63:0] x, logic [63:0] y,
                                         logic [63:0] z);
        if (v >= MaxStoredVertices || !pos_x.exists(v))
            return 1'b0;
        return ieee_equal(pos_x[v], x) && ieee_equal(pos_y[v], y) && ieee_equal(pos_z[v], z);
    endfunction

    // First slot of a grid vertex; indices wrap without bound checks
    function automatic int unsigned slot_base(int unsigned i, int unsigned j, int unsigned k);
        int unsigned ni;
        int unsigned nj;
        ni = cells_i + 1;
        nj = cells_j + 1;
        return ((k * ni * nj + j * ni + i) % MaxGridVertices) * SlotsPerVertex;
    endfunction

    // Scan a neighbour layer up to its first empty slot; -1 when no match
    function automatic int layer_lookup(int unsigned base, logic [63:0] x, logic [63:0] y,
                                        logic [63:0] z);
        for (int s = 0; s < SlotsPerVertex; s++) begin
            if (!slot_map.exists(base + s))
                return -1;
            if (point_matches(slot_map[base + s] - 1, x, y, z))
                return int'(slot_map[base + s] - 1);
        end
        return -1;
    endfunction

    function automatic weld_t weld_corner(logic [7:0] vi, logic [7:0] vj, logic [7:0] vk,
                                          logic [63:0] x, logic [63:0] y, logic [63:0] z);
        weld_t       r;
        int unsigned base;
        int unsigned hit;
        int          found;
        bit          done;
        r = '0;
        done = 1'b0;
        base = slot_base(vi, vj, vk);
        for (int s = 0; s < SlotsPerVertex && !done; s++) begin
            if (!slot_map.exists(base + s)) begin
                found = -1;
                if (vk > 0)
                    found = layer_lookup(slot_base(vi, vj, vk - 1), x, y, z);
                if (found < 0 && vk < cells_k)
                    found = layer_lookup(slot_base(vi, vj, vk + 1), x, y, z);
                if (found >= 0) begin
                    slot_map[base + s] = found + 1;
                    r.vtx = found[17:0];
                end else if (vertex_count >= MaxStoredVertices) begin
                    r.store_full = 1'b1;
                end else begin
                    r.vtx = vertex_count[17:0];
                    pos_x[vertex_count] = x;
                    pos_y[vertex_count] = y;
                    pos_z[vertex_count] = z;
                    vertex_count++;
                    slot_map[base + s] = vertex_count;
                    r.fresh = 1'b1;
                end
                done = 1'b1;
            end else begin
                hit = slot_map[base + s] - 1;
                r.vtx = hit[17:0];
                if (point_matches(hit, x, y, z))
                    done = 1'b1;
            end
        end
        r.slots_full = !done;
        r.total = vertex_count[18:0];
        return r;
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Assumes the caller sits at a falling edge; leaves valid high so that
    // back-to-back writes never drop and raise it in the same step.
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            RegCellsI: cells_i = 32'(val);
            RegCellsJ: cells_j = 32'(val);
            RegCellsK: cells_k = 32'(val);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Offer one item after a gap; leave tvalid high so back-to-back items
    // never see a drop and raise in the same step.
    task automatic send_corner(logic [7:0] vi, logic [7:0] vj, logic [7:0] vk,
                               logic [63:0] x, logic [63:0] y, logic [63:0] z,
                               int gap, bit typed, weld_t want);
        weld_t pred;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x, vk, vj, vi};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = weld_corner(vi, vj, vk, x, y, z);
        expected_welds.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    // Wait until every result is back, then let the block go quiet.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_welds.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold when asked, check each item
    // ------------------------------------------------------------------
    initial begin
        int    stall;
        weld_t got;
        weld_t want;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                stall = 400;
                long_hold_req = 1'b0;
            end else begin
                stall = rx_no_stall ? 0 : $urandom_range(0, 12);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.vtx        = m_axis_tdata[17:0];
            got.fresh      = m_axis_tdata[18];
            got.slots_full = m_axis_tdata[19];
            got.store_full = m_axis_tdata[20];
            got.total      = m_axis_tdata[39:21];
            if (expected_welds.size() == 0) begin
                report($sformatf("unexpected result item %h", m_axis_tdata));
            end else begin
                want = expected_welds.pop_front();
                if (got.vtx != want.vtx)
                    report($sformatf("vertex_index %0d, want %0d", got.vtx, want.vtx));
                if (got.fresh != want.fresh)
                    report($sformatf("is_new %0b, want %0b", got.fresh, want.fresh));
                if (got.slots_full != want.slots_full)
                    report($sformatf("slots_full %0b, want %0b",
                                     got.slots_full, want.slots_full));
                if (got.store_full != want.store_full)
                    report($sformatf("store_full %0b, want %0b",
                                     got.store_full, want.store_full));
                if (got.total != want.total)
                    report($sformatf("vertex_total %0d, want %0d", got.total, want.total));
            end
            @(negedge i_clk);
        end
    end

    // Hang detector: count cycles in which no item of any channel moves
    int unsigned quiet_cycles;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HangLimit) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Directed corners under the reset grid 1x1x1: fill slots at (0,0,0),
    // weld across layers, signed zeros, NaN, infinity, then overflow the
    // eight slots and hit out-of-range indices.
    corner_row_t directed [17] = '{
        '{0, 0, 0, F_ONE, F_ONE, F_ONE, 1'b1, '{0, 1, 0, 0, 1}},
        '{0, 0, 0, F_ONE, F_ONE, F_ONE, 1'b1, '{0, 0, 0, 0, 1}},
        '{0, 0, 0, F_PZ, F_PZ, F_PZ, 1'b1, '{1, 1, 0, 0, 2}},
        '{0, 0, 0, F_NZ, F_NZ, F_NZ, 1'b1, '{1, 0, 0, 0, 2}},
        '{0, 0, 0, F_QNAN, F_ONE, F_ONE, 1'b1, '{2, 1, 0, 0, 3}},
        '{0, 0, 0, F_QNAN, F_ONE, F_ONE, 1'b1, '{3, 1, 0, 0, 4}},
        '{0, 0, 1, F_ONE, F_ONE, F_ONE, 1'b0, '0},
        '{0, 0, 1, F_TWO, F_TWO, F_TWO, 1'b0, '0},
        '{0, 0, 0, F_TWO, F_TWO, F_TWO, 1'b0, '0},
        '{0, 0, 0, F_INF, F_INF, F_INF, 1'b0, '0},
        '{0, 0, 0, F_MAX, F_MAX, F_MAX, 1'b0, '0},
        '{0, 0, 0, F_MONE, F_MONE, F_MONE, 1'b0, '0},
        '{0, 0, 0, F_ONES, F_ONES, F_ONES, 1'b0, '0},
        '{255, 255, 255, F_ONE, F_ONE, F_ONE, 1'b0, '0},
        '{1, 1, 1, F_NZ, F_PZ, F_NZ, 1'b0, '0},
        '{1, 1, 0, F_PZ, F_NZ, F_PZ, 1'b0, '0},
        '{0, 255, 0, F_ONE, F_TWO, F_ONE, 1'b0, '0}
    };

    // Grid sizes per phase: reset default, zero registers, the largest, mixed
    logic [7:0] phase_grid [6][3] = '{
        '{1, 1, 1}, '{0, 0, 0}, '{255, 255, 255}, '{2, 3, 1}, '{3, 1, 4}, '{1, 2, 2}
    };

    logic [63:0] coord_pool [8];

    function automatic logic [63:0] any_bits();
        return {$urandom(), $urandom()};
    endfunction

    // Index near the low corner mostly, at the grid edge or anywhere sometimes
    function automatic logic [7:0] pick_index(int unsigned cells);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 8'($urandom_range(0, 255));
        if (roll == 1)
            return cells[7:0];
        return 8'($urandom_range(0, cells < 3 ? cells : 3));
    endfunction

    function automatic logic [63:0] pick_coord();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return any_bits();
        if (roll == 1)
            return F_NZ;
        return coord_pool[$urandom_range(0, 7)];
    endfunction

    initial begin
        int gap;
        int calm_left;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = RegCellsI;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        errors        = 0;
        long_hold_req = 1'b0;
        rx_no_stall   = 1'b0;
        vertex_count  = 0;
        cells_i       = 1;
        cells_j       = 1;
        cells_k       = 1;
        calm_left     = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[n])
            send_corner(directed[n].vi, directed[n].vj, directed[n].vk, directed[n].x,
                        directed[n].y, directed[n].z, $urandom_range(0, 12),
                        directed[n].typed, directed[n].want);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(RegCellsI, phase_grid[p][0]);
            write_reg(RegCellsJ, phase_grid[p][1]);
            write_reg(RegCellsK, phase_grid[p][2]);
            i_cfg_valid <= 1'b0;
            // Fresh point set per phase; zero and one kept among them, NaN when p is 2
            foreach (coord_pool[c])
                coord_pool[c] = any_bits();
            coord_pool[0] = F_PZ;
            coord_pool[1] = F_ONE;
            if (p == 2)
                coord_pool[7] = F_QNAN;
            for (int n = 0; n < PhaseItems; n++) begin
                // Switch between stretches with and without gaps
                if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 24) == 0) begin
                    calm_left = 20;
                end
                rx_no_stall = (calm_left > 0);
                gap = (calm_left > 0) ? 0 : $urandom_range(0, 12);
                // Starve the result side once while items keep coming
                if (p == 1 && n == 10)
                    long_hold_req = 1'b1;
                send_corner(pick_index(cells_i), pick_index(cells_j), pick_index(cells_k),
                            pick_coord(), pick_coord(), pick_coord(), gap, 1'b0, '0);
            end
            rx_no_stall = 1'b0;
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
